/* design/assert_macros.svh */
// Shared assertion macros for the design folder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define AST_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define AST_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* design/bcim_pkg.sv */
package bcim_pkg;

	localparam int IDX_W     = 20;
	localparam int NB_W      = 13;
	localparam int P_W       = 9;
	localparam int OWN_W     = 8;
	localparam int DIV_STEPS = IDX_W;
	localparam int ADDR_W    = 4;
	localparam int LOC_W     = IDX_W + NB_W + 1;
	localparam int GLB_W     = IDX_W + P_W + 1 + NB_W + 1;

	localparam logic [NB_W-1:0] MAX_BLOCK = 13'd4096;
	localparam logic [P_W-1:0]  MAX_PROCS = 9'd256;

	localparam logic [1:0] REG_BLOCK = 2'd0;
	localparam logic [1:0] REG_PROWS = 2'd1;
	localparam logic [1:0] REG_PCOLS = 2'd2;

	localparam logic CMD_TO_LOCAL  = 1'b0;
	localparam logic CMD_TO_GLOBAL = 1'b1;

	typedef struct packed {
		logic [NB_W-1:0] nb;
		logic [P_W-1:0]  pr;
		logic [P_W-1:0]  pc;
	} cfg_t;

	typedef struct packed {
		logic             cmd;
		logic [OWN_W-1:0] own_r;
		logic [OWN_W-1:0] own_c;
		logic [NB_W-1:0]  rem_r;
		logic [NB_W-1:0]  rem_c;
		logic [IDX_W-1:0] quo_r;
		logic [IDX_W-1:0] quo_c;
		logic [NB_W-1:0]  sav_r;
		logic [NB_W-1:0]  sav_c;
		logic [IDX_W-1:0] sq_r;
		logic [IDX_W-1:0] sq_c;
	} item_t;

	typedef struct packed {
		logic [OWN_W-1:0] own_r;
		logic [OWN_W-1:0] own_c;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic             ovf;
	} res_t;

	// One restoring division step: shifts the next dividend bit into the
	// partial remainder and shifts the quotient bit into the dividend word.
	function automatic logic [NB_W+IDX_W-1:0] div_step(input logic [NB_W-1:0] rem,
		input logic [IDX_W-1:0] quo, input logic [NB_W-1:0] d);
		logic [NB_W:0] trial;
		logic [NB_W:0] diff;
		trial = {rem, quo[IDX_W-1]};
		diff  = trial - {1'b0, d};
		if (trial >= {1'b0, d}) begin
			div_step = {diff[NB_W-1:0], quo[IDX_W-2:0], 1'b1};
		end else begin
			div_step = {trial[NB_W-1:0], quo[IDX_W-2:0], 1'b0};
		end
	endfunction

endpackage

/* design/block_cyclic_index_map_2d.sv */
// Two-dimensional block-cyclic index translator. Each transaction on the
// slave stream carries a command in s_tuser: zero maps a global row and
// column to the owning process coordinates and the local index on that
// process, one maps a local index plus owner coordinates back to the global
// index and raises the overflow flag when a result does not fit in 20 bits.
// The block takes one transaction per clock cycle unless back-pressured and
// returns exactly one result per transaction, in order. The pipeline has 42
// register stages: two pipelined restoring dividers of 20 stages each (one
// quotient bit per stage, first by the block size, then by the process
// count), followed by two multiply stages.
// Back-pressure on the master side stalls only the stages that are full, so
// bubbles are squeezed out. Registers sit
// on the APB port at byte addresses 0 (block_size), 4 (proc_rows) and
// 8 (proc_cols); a zero value acts as one and larger values saturate at
// 4096 and 256. Write them only while no transaction is in flight.
`include "assert_macros.svh"

module block_cyclic_index_map_2d import bcim_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              s_tvalid,
	output logic              s_tready,
	// Fields from bit 0: row_in[19:0], col_in[39:20], owner_row_in[47:40],
	// owner_col_in[55:48].
	input  logic [55:0]       s_tdata,
	// Fields from bit 0: command.
	input  logic              s_tuser,
	output logic              m_tvalid,
	input  logic              m_tready,
	// Fields from bit 0: owner_row_out[7:0], owner_col_out[15:8],
	// row_out[35:16], col_out[55:36], overflow[56], zero fill above.
	output logic [63:0]       m_tdata
);

	cfg_t  cfg;
	item_t in_item;
	item_t d1_item;
	item_t mid_item;
	item_t d2_item;
	logic  d1_valid;
	logic  d1_ready;
	logic  d2_valid;
	logic  d2_ready;
	res_t  res;

	bcim_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The dividend starts in the quotient word with a cleared remainder.
	always_comb begin
		in_item       = '0;
		in_item.cmd   = s_tuser;
		in_item.quo_r = s_tdata[IDX_W-1:0];
		in_item.quo_c = s_tdata[2*IDX_W-1:IDX_W];
		in_item.own_r = s_tdata[2*IDX_W+OWN_W-1:2*IDX_W];
		in_item.own_c = s_tdata[2*IDX_W+2*OWN_W-1:2*IDX_W+OWN_W];
	end

	// First pass: index divided by the block size.
	bcim_div u_div_blk (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_item   (in_item),
		.d_row     (cfg.nb),
		.d_col     (cfg.nb),
		.out_valid (d1_valid),
		.out_ready (d1_ready),
		.out_item  (d1_item)
	);

	// Keep the block number and the offset in the block, then divide the
	// block number by the process count.
	always_comb begin
		mid_item       = d1_item;
		mid_item.sav_r = d1_item.rem_r;
		mid_item.sav_c = d1_item.rem_c;
		mid_item.sq_r  = d1_item.quo_r;
		mid_item.sq_c  = d1_item.quo_c;
		mid_item.rem_r = '0;
		mid_item.rem_c = '0;
	end

	bcim_div u_div_proc (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (d1_valid),
		.in_ready  (d1_ready),
		.in_item   (mid_item),
		.d_row     ({{(NB_W-P_W){1'b0}}, cfg.pr}),
		.d_col     ({{(NB_W-P_W){1'b0}}, cfg.pc}),
		.out_valid (d2_valid),
		.out_ready (d2_ready),
		.out_item  (d2_item)
	);

	bcim_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (d2_valid),
		.in_ready  (d2_ready),
		.in_item   (d2_item),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	assign m_tdata = {7'd0, res.ovf, res.col, res.row, res.own_c, res.own_r};

	// With the output stage empty, every stage can advance.
	`AST_IMPL(a_ready_when_drained, !m_tvalid, s_tready)
	// Overflow only comes from the local-to-global direction, whose owners are zero.
	`AST_IMPL(a_ovf_owner_zero, m_tvalid && m_tdata[56], m_tdata[15:0] == 16'd0)
	// A write of zero to the block size still gives a usable divisor.
	`AST_NEXT(a_nb_nonzero, psel && penable && pwrite && paddr[3:2] == REG_BLOCK, cfg.nb != '0)

endmodule

/* design/bcim_cfg.sv */
module bcim_cfg import bcim_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic [NB_W-1:0] blk_q;
	logic [P_W-1:0]  prw_q;
	logic [P_W-1:0]  pcw_q;
	logic            wr;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_q <= NB_W'(2);
			prw_q <= P_W'(2);
			pcw_q <= P_W'(2);
		end else if (wr) begin
			unique case (paddr[3:2])
				REG_BLOCK: blk_q <= pwdata[NB_W-1:0];
				REG_PROWS: prw_q <= pwdata[P_W-1:0];
				REG_PCOLS: pcw_q <= pwdata[P_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_BLOCK: prdata = {{(32-NB_W){1'b0}}, blk_q};
			REG_PROWS: prdata = {{(32-P_W){1'b0}}, prw_q};
			REG_PCOLS: prdata = {{(32-P_W){1'b0}}, pcw_q};
			default:   prdata = 32'd0;
		endcase
	end

	// Zero counts as one; values past the range saturate.
	always_comb begin
		cfg.nb = (blk_q == '0) ? NB_W'(1) : ((blk_q > MAX_BLOCK) ? MAX_BLOCK : blk_q);
		cfg.pr = (prw_q == '0) ? P_W'(1) : ((prw_q > MAX_PROCS) ? MAX_PROCS : prw_q);
		cfg.pc = (pcw_q == '0) ? P_W'(1) : ((pcw_q > MAX_PROCS) ? MAX_PROCS : pcw_q);
	end

endmodule

/* design/bcim_div.sv */
module bcim_div import bcim_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  item_t           in_item,
	input  logic [NB_W-1:0] d_row,
	input  logic [NB_W-1:0] d_col,
	output logic            out_valid,
	input  logic            out_ready,
	output item_t           out_item
);

	logic [DIV_STEPS-1:0] vld_s;
	item_t                dat_s [DIV_STEPS];
	logic [DIV_STEPS:0]   adv;

	assign adv[DIV_STEPS] = out_ready;
	assign in_ready       = adv[0];
	assign out_valid      = vld_s[DIV_STEPS-1];
	assign out_item       = dat_s[DIV_STEPS-1];

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_stage
		item_t src;
		item_t nxt;
		logic  src_vld;

		if (k == 0) begin : g_first
			assign src     = in_item;
			assign src_vld = in_valid;
		end else begin : g_rest
			assign src     = dat_s[k-1];
			assign src_vld = vld_s[k-1];
		end

		assign adv[k] = !vld_s[k] || adv[k+1];

		always_comb begin
			nxt = src;
			{nxt.rem_r, nxt.quo_r} = div_step(src.rem_r, src.quo_r, d_row);
			{nxt.rem_c, nxt.quo_c} = div_step(src.rem_c, src.quo_c, d_col);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv[k]) begin
				vld_s[k] <= src_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (adv[k] && src_vld) begin
				dat_s[k] <= nxt;
			end
		end
	end

endmodule

/* design/bcim_mac.sv */
module bcim_mac import bcim_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	output logic  out_valid,
	input  logic  out_ready,
	output res_t  out_res
);

	logic             vld_s1;
	logic             cmd_s1;
	logic [OWN_W-1:0] own_r_s1;
	logic [OWN_W-1:0] own_c_s1;
	logic [LOC_W-1:0] acc_r_s1;
	logic [LOC_W-1:0] acc_c_s1;
	logic [NB_W-1:0]  sav_r_s1;
	logic [NB_W-1:0]  sav_c_s1;
	logic             vld_s2;
	res_t             res_s2;
	logic             adv1;
	logic             adv2;
	logic [GLB_W-1:0] g_r;
	logic [GLB_W-1:0] g_c;

	assign adv2      = !vld_s2 || out_ready;
	assign adv1      = !vld_s1 || adv2;
	assign in_ready  = adv1;
	assign out_valid = vld_s2;
	assign out_res   = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (adv1) vld_s1 <= in_valid;
			if (adv2) vld_s2 <= vld_s1;
		end
	end

	// First product: local index, or block position scaled by the grid size.
	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			cmd_s1   <= in_item.cmd;
			sav_r_s1 <= in_item.sav_r;
			sav_c_s1 <= in_item.sav_c;
			if (in_item.cmd == CMD_TO_LOCAL) begin
				own_r_s1 <= in_item.rem_r[OWN_W-1:0];
				own_c_s1 <= in_item.rem_c[OWN_W-1:0];
				acc_r_s1 <= LOC_W'(in_item.quo_r) * LOC_W'(cfg.nb) + LOC_W'(in_item.sav_r);
				acc_c_s1 <= LOC_W'(in_item.quo_c) * LOC_W'(cfg.nb) + LOC_W'(in_item.sav_c);
			end else begin
				own_r_s1 <= '0;
				own_c_s1 <= '0;
				acc_r_s1 <= LOC_W'(in_item.sq_r) * LOC_W'(cfg.pr) + LOC_W'(in_item.own_r);
				acc_c_s1 <= LOC_W'(in_item.sq_c) * LOC_W'(cfg.pc) + LOC_W'(in_item.own_c);
			end
		end
	end

	assign g_r = GLB_W'(acc_r_s1) * GLB_W'(cfg.nb) + GLB_W'(sav_r_s1);
	assign g_c = GLB_W'(acc_c_s1) * GLB_W'(cfg.nb) + GLB_W'(sav_c_s1);

	always_ff @(posedge clk) begin
		if (adv2 && vld_s1) begin
			res_s2.own_r <= own_r_s1;
			res_s2.own_c <= own_c_s1;
			if (cmd_s1 == CMD_TO_LOCAL) begin
				res_s2.row <= acc_r_s1[IDX_W-1:0];
				res_s2.col <= acc_c_s1[IDX_W-1:0];
				res_s2.ovf <= 1'b0;
			end else begin
				res_s2.row <= g_r[IDX_W-1:0];
				res_s2.col <= g_c[IDX_W-1:0];
				res_s2.ovf <= (g_r[GLB_W-1:IDX_W] != '0) || (g_c[GLB_W-1:IDX_W] != '0);
			end
		end
	end

endmodule
